>>> rtl/two_link_arm_dynamics_terms_macros.svh
// Assertion macros shared by the block's modules.
`ifndef TWO_LINK_ARM_DYNAMICS_TERMS_MACROS_SVH
`define TWO_LINK_ARM_DYNAMICS_TERMS_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define TLA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tla_pkg.sv
`timescale 1ns / 1ps
package tla_pkg;
   localparam int AngleWidth = 20;
   localparam int DataWidth = 32;
   localparam int PhaseWidth = 32;
   localparam int CsrIndexWidth = 3;
   localparam int Depth = 12;

   localparam logic [CsrIndexWidth-1:0] CSR_BASE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_COUP = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_ELBOW = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SGRAV = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_EGRAV = 3'd4;

   localparam logic signed [31:0] PHASE_GAIN = 32'sd683565276;
   localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam logic signed [31:0] HORNER_C0 = 32'sd2959;
   localparam logic signed [31:0] HORNER_C1 = 32'sd213044;
   localparam logic signed [31:0] HORNER_C2 = 32'sd8947849;
   localparam logic signed [31:0] HORNER_C3 = 32'sd178956971;
   localparam logic signed [31:0] HORNER_START = 32'sd27;

   typedef struct packed {
      logic signed [31:0] base;
      logic signed [31:0] coup;
      logic signed [31:0] elbow;
      logic signed [31:0] sgrav;
      logic signed [31:0] egrav;
   } coef_type;

   // Round half up by 2^30 of a 64-bit product.
   function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd536870912;
      return t[63:30];
   endfunction
endpackage

>>> rtl/tla_sine.sv
`timescale 1ns / 1ps
`include "two_link_arm_dynamics_terms_macros.svh"
// Pipelined sine: phase in turns to Q30 sine, at most one multiply per stage.
module tla_sine (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [31:0] phase,
   output logic signed [31:0] sine
);
   // Stage 0: fold and scale to radians.
   logic signed [32:0] fold;
   logic signed [31:0] r_ff [0:6];
   // The square reaches (pi/2)^2 in Q30, which needs 33 signed bits.
   logic signed [32:0] r2_ff [1:5];
   logic signed [31:0] t_ff [2:7];
   logic signed [31:0] s_ff;
   logic signed [32:0] ps;
   logic [7:0] v_ff;

   always_comb begin
      ps = {phase[31], phase};
      if (ps > $signed({1'b0, tla_pkg::QUARTER_TURN}))
         fold = 33'sh0_8000_0000 - ps;
      else if (ps < -$signed({1'b0, tla_pkg::QUARTER_TURN}))
         fold = -33'sh0_8000_0000 - ps;
      else
         fold = ps;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[6:0], in_valid};
      r_ff[0] <= 32'(tla_pkg::rnd30(64'(fold) * 64'(tla_pkg::HALF_PI_Q30)));
      r_ff[1] <= r_ff[0];
      r2_ff[1] <= 33'(tla_pkg::rnd30(64'(r_ff[0]) * 64'(r_ff[0])));
      for (int i = 2; i < 7; i++) begin
         r_ff[i] <= r_ff[i-1];
      end
      for (int i = 2; i < 6; i++) begin
         r2_ff[i] <= r2_ff[i-1];
      end
      t_ff[2] <= tla_pkg::HORNER_C0
                 - 32'(tla_pkg::rnd30(64'(r2_ff[1]) * 64'(tla_pkg::HORNER_START)));
      t_ff[3] <= tla_pkg::HORNER_C1 - 32'(tla_pkg::rnd30(64'(r2_ff[2]) * 64'(t_ff[2])));
      t_ff[4] <= tla_pkg::HORNER_C2 - 32'(tla_pkg::rnd30(64'(r2_ff[3]) * 64'(t_ff[3])));
      t_ff[5] <= tla_pkg::HORNER_C3 - 32'(tla_pkg::rnd30(64'(r2_ff[4]) * 64'(t_ff[4])));
      t_ff[6] <= tla_pkg::ONE_Q30 - 32'(tla_pkg::rnd30(64'(r2_ff[5]) * 64'(t_ff[5])));
      t_ff[7] <= 32'(tla_pkg::rnd30(64'(r_ff[6]) * 64'(t_ff[6])));
      if (t_ff[7] > tla_pkg::ONE_Q30) s_ff <= tla_pkg::ONE_Q30;
      else if (t_ff[7] < -tla_pkg::ONE_Q30) s_ff <= -tla_pkg::ONE_Q30;
      else s_ff <= t_ff[7];
   end
   assign sine = s_ff;

   `TLA_ASSERT_NEXT(a_sine_range, clock, reset, v_ff[7], (s_ff <= tla_pkg::ONE_Q30) && (s_ff >= -tla_pkg::ONE_Q30), "sine out of range")
   `TLA_ASSERT_NEXT(a_valid_shift, clock, reset, in_valid, v_ff[0], "valid lost")
   `TLA_ASSERT_NEXT(a_valid_mid, clock, reset, v_ff[3], v_ff[4], "valid lost mid pipe")
endmodule

>>> rtl/tla_combine.sv
`timescale 1ns / 1ps
`include "two_link_arm_dynamics_terms_macros.svh"
// Products of coefficients and sines, Q46 sums, rounding and saturation.
module tla_combine (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  tla_pkg::coef_type coef,
   input  logic signed [31:0] cos2,
   input  logic signed [31:0] sin1,
   input  logic signed [31:0] sin12,
   output logic out_valid,
   output logic signed [31:0] m00,
   output logic signed [31:0] m01,
   output logic signed [31:0] m11,
   output logic signed [31:0] g0,
   output logic signed [31:0] g1
);
   logic signed [63:0] cc_ff, sg_ff, eg_ff;
   logic signed [65:0] a00_ff, a01_ff, ag0_ff, ag1_ff;
   logic signed [31:0] m00_ff, m01_ff, g0_ff, g1_ff;
   logic [2:0] v_ff;

   function automatic logic signed [31:0] fin(input logic signed [65:0] a);
      logic signed [65:0] t;
      logic signed [35:0] v;
      t = a + 66'sd536870912;
      v = t[65:30];
      if (v > 36'sd2147483647) return 32'h7fff_ffff;
      if (v < -36'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[1:0], in_valid};
      cc_ff <= 64'(coef.coup) * 64'(cos2);
      sg_ff <= 64'(coef.sgrav) * 64'(sin1);
      eg_ff <= 64'(coef.egrav) * 64'(sin12);
      a00_ff <= (66'(coef.base) <<< 30) + (66'(cc_ff) <<< 1);
      a01_ff <= (66'(coef.elbow) <<< 30) + 66'(cc_ff);
      ag0_ff <= 66'(sg_ff) + 66'(eg_ff);
      ag1_ff <= 66'(eg_ff);
      m00_ff <= fin(a00_ff);
      m01_ff <= fin(a01_ff);
      g0_ff <= fin(ag0_ff);
      g1_ff <= fin(ag1_ff);
   end

   assign out_valid = v_ff[2];
   assign m00 = m00_ff;
   assign m01 = m01_ff;
   assign m11 = coef.elbow;
   assign g0 = g0_ff;
   assign g1 = g1_ff;

   `TLA_ASSERT_NEXT(a_comb_v1, clock, reset, in_valid, v_ff[0], "valid lost")
   `TLA_ASSERT_NEXT(a_comb_v2, clock, reset, v_ff[1], out_valid, "valid lost at output")
   `TLA_ASSERT_NEXT(a_comb_g1, clock, reset, v_ff[1] && (ag1_ff == 66'sd0), g1_ff == 32'sd0, "zero torque")
endmodule

>>> rtl/two_link_arm_dynamics_terms.sv
`timescale 1ns / 1ps
// Two-link planar arm dynamics terms: inertia matrix and gravity torques.
//
// A transaction is offered on req_joint_angle_1/2 (Q3.16 radians) with
// start; it is taken at each clock edge where start is high and busy is
// low. busy is always low here, so one transaction can enter every cycle.
// Each result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid. The receiver cannot stall the block and need not: nothing
// upstream waits on it. The path runs through a phase stage in front,
// the sine pipeline (nine stages: fold and scale, squaring, five Horner
// steps, final multiply, clamp) and three combine stages (coefficient
// products, Q46 sums, rounding and saturation).
// Throughput is one transaction per cycle.
// Coefficients come in through csr_write_enable, csr_index, csr_write_data;
// indexes past the fifth register are ignored. Write them only when idle.
// Synchronous reset clears all coefficients to zero and drops every
// transaction in flight.
module two_link_arm_dynamics_terms (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [19:0] req_joint_angle_1,
   input  logic signed [19:0] req_joint_angle_2,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_write_data,
   output logic rsp_valid,
   output logic signed [31:0] rsp_inertia_00,
   output logic signed [31:0] rsp_inertia_01,
   output logic signed [31:0] rsp_inertia_10,
   output logic signed [31:0] rsp_inertia_11,
   output logic signed [31:0] rsp_gravity_0,
   output logic signed [31:0] rsp_gravity_1
);
   tla_pkg::coef_type coef_ff;
   logic [31:0] p1_ff, p2_ff, p12_ff;
   logic pv_ff;
   logic signed [20:0] a12;
   logic signed [31:0] cos2, sin1, sin12;
   logic signed [31:0] m01;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tla_pkg::CSR_BASE:  coef_ff.base <= csr_write_data;
            tla_pkg::CSR_COUP:  coef_ff.coup <= csr_write_data;
            tla_pkg::CSR_ELBOW: coef_ff.elbow <= csr_write_data;
            tla_pkg::CSR_SGRAV: coef_ff.sgrav <= csr_write_data;
            tla_pkg::CSR_EGRAV: coef_ff.egrav <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Phase in turns: the 32-bit wrap is the reduction modulo two pi.
   function automatic logic [31:0] to_phase(input logic signed [20:0] a);
      logic signed [63:0] prod;
      prod = 64'(a) * 64'(tla_pkg::PHASE_GAIN) + 64'sd32768;
      return prod[47:16];
   endfunction

   assign a12 = 21'(req_joint_angle_1) + 21'(req_joint_angle_2);

   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else pv_ff <= start && !busy;
      p1_ff <= to_phase(21'(req_joint_angle_1));
      p2_ff <= to_phase(21'(req_joint_angle_2)) + tla_pkg::QUARTER_TURN;
      p12_ff <= to_phase(a12);
   end

   logic sv_unused1, sv_unused2;
   tla_sine u_cos2 (.clock, .reset, .in_valid(pv_ff), .phase(p2_ff), .sine(cos2));
   tla_sine u_sin1 (.clock, .reset, .in_valid(pv_ff), .phase(p1_ff), .sine(sin1));
   tla_sine u_sin12 (.clock, .reset, .in_valid(pv_ff), .phase(p12_ff), .sine(sin12));

   // Valid shifted alongside the sine units, leaving with their results.
   logic [8:0] sv_ff;
   always_ff @(posedge clock) begin
      if (reset) sv_ff <= '0;
      else sv_ff <= {sv_ff[7:0], pv_ff};
   end
   assign sv_unused1 = sv_ff[8];
   assign sv_unused2 = sv_unused1;

   tla_combine u_combine (
      .clock, .reset, .in_valid(sv_unused2), .coef(coef_ff),
      .cos2, .sin1, .sin12,
      .out_valid(rsp_valid), .m00(rsp_inertia_00), .m01(m01),
      .m11(rsp_inertia_11), .g0(rsp_gravity_0), .g1(rsp_gravity_1)
   );
   assign rsp_inertia_01 = m01;
   assign rsp_inertia_10 = m01;
endmodule
